/* hdl/jsu_pkg.sv */
package jsu_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_B         = 8'h62;
  localparam logic [7:0] CHAR_F         = 8'h66;
  localparam logic [7:0] CHAR_N         = 8'h6E;
  localparam logic [7:0] CHAR_R         = 8'h72;
  localparam logic [7:0] CHAR_T         = 8'h74;
  localparam logic [7:0] CHAR_U         = 8'h75;

  localparam logic [3:0] DFA_ACCEPT = 4'd0;
  localparam logic [3:0] DFA_REJECT = 4'd1;
  localparam int         DFA_STATES = 9;
  localparam int         DFA_CLASSES = 12;

  typedef enum logic [2:0] {
    MODE_PLAIN  = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX1   = 3'd2,
    MODE_HEX2   = 3'd3,
    MODE_HEX3   = 3'd4,
    MODE_HEX4   = 3'd5,
    MODE_LOW_BS = 3'd6,
    MODE_LOW_U  = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_MALFORMED  = 2'd1,
    STATUS_INCOMPLETE = 2'd2
  } status_t;

  // UTF-8 automaton: rows are states, columns are byte classes
  localparam logic [3:0] DFA_NEXT [DFA_STATES][DFA_CLASSES] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  typedef struct packed {
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
  } utf8_enc_t;

  // One queue entry: everything a single input transaction produces
  typedef struct packed {
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
    logic            has_status;
    status_t         status;
    logic [15:0]     length;
  } bundle_t;

  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] c;
    priority if (b < 8'h80)  c = 4'd0;
    else if (b < 8'h90)      c = 4'd1;
    else if (b < 8'hA0)      c = 4'd9;
    else if (b < 8'hC0)      c = 4'd7;
    else if (b < 8'hC2)      c = 4'd8;
    else if (b < 8'hE0)      c = 4'd2;
    else if (b == 8'hE0)     c = 4'd10;
    else if (b == 8'hED)     c = 4'd4;
    else if (b < 8'hF0)      c = 4'd3;
    else if (b == 8'hF0)     c = 4'd11;
    else if (b < 8'hF4)      c = 4'd6;
    else if (b == 8'hF4)     c = 4'd5;
    else                     c = 4'd8;
    return c;
  endfunction

  // Returns {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    priority if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66)     r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46)     r = {1'b1, 4'(c - 8'h37)};
    else                                   r = 5'd0;
    return r;
  endfunction

  function automatic utf8_enc_t encode_point(input logic [20:0] cp);
    utf8_enc_t e;
    e = '0;
    priority if (cp <= 21'h7F) begin
      e.nbytes   = 3'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      e.nbytes   = 3'd2;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      e.nbytes   = 3'd3;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.nbytes   = 3'd4;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

/* hdl/jsu_front.sv */
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_byte_valid,
  input  logic       in_last,
  output logic       in_ready,
  input  logic       q_full,
  output logic       push,
  output bundle_t    push_data
);

  mode_t                  mode, mode_next;
  logic [3:0]             dfa_state, dfa_state_next;
  logic [15:0]            code_unit, code_unit_next;
  logic [9:0]             high_half, high_half_next;
  logic                   pair_pending, pair_pending_next;
  logic                   error_flag, error_flag_next;
  logic [COUNT_BITS-1:0]  byte_count, byte_count_next;

  logic            take, proc, err_now;
  logic [3:0]      cls, dfa_after;
  logic [4:0]      hexv;
  logic [15:0]     cu_shift;
  logic            is_high, is_low;
  logic [20:0]     cp_sel;
  utf8_enc_t       enc;
  logic [2:0]      nbytes;
  logic [3:0][7:0] bytes;
  logic [COUNT_BITS:0] count_sum;
  logic [31:0]     count_ext;
  status_t         status;

  assign in_ready = !q_full;
  assign take     = in_valid && !q_full;
  assign proc     = in_byte_valid && !error_flag;

  assign cls       = byte_class(in_byte);
  assign dfa_after = (dfa_state < 4'(DFA_STATES)) ? DFA_NEXT[dfa_state][cls] : DFA_REJECT;
  assign hexv      = hex_value(in_byte);
  assign cu_shift  = {code_unit[11:0], hexv[3:0]};
  assign is_high   = (cu_shift[15:10] == 6'b110110);
  assign is_low    = (cu_shift[15:10] == 6'b110111);
  assign cp_sel    = pair_pending ? (21'h10000 + 21'({high_half, cu_shift[9:0]}))
                                  : 21'(cu_shift);
  assign enc       = encode_point(cp_sel);

  // Parse mode
  always_comb begin
    mode_next = mode;
    if (proc) begin
      unique case (mode)
        MODE_PLAIN:  if (in_byte == CHAR_BACKSLASH) mode_next = MODE_ESC;
        MODE_ESC:    mode_next = (in_byte == CHAR_U) ? MODE_HEX1 : MODE_PLAIN;
        MODE_LOW_BS: mode_next = MODE_LOW_U;
        MODE_LOW_U:  mode_next = MODE_HEX1;
        MODE_HEX1:   mode_next = MODE_HEX2;
        MODE_HEX2:   mode_next = MODE_HEX3;
        MODE_HEX3:   mode_next = MODE_HEX4;
        MODE_HEX4:   mode_next = (!pair_pending && is_high) ? MODE_LOW_BS : MODE_PLAIN;
      endcase
    end
  end

  // Decoded bytes, errors and the rest of the state
  always_comb begin
    err_now           = 1'b0;
    nbytes            = 3'd0;
    bytes             = '0;
    dfa_state_next    = dfa_state;
    code_unit_next    = code_unit;
    high_half_next    = high_half;
    pair_pending_next = pair_pending;
    if (proc) begin
      unique case (mode)
        MODE_PLAIN: begin
          dfa_state_next = dfa_after;
          if (dfa_after == DFA_REJECT) begin
            err_now = 1'b1;
          end else if (in_byte != CHAR_BACKSLASH) begin
            nbytes   = 3'd1;
            bytes[0] = in_byte;
          end
        end
        MODE_ESC: begin
          nbytes = 3'd1;
          unique case (in_byte)
            CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: bytes[0] = in_byte;
            CHAR_B: bytes[0] = 8'h08;
            CHAR_F: bytes[0] = 8'h0C;
            CHAR_N: bytes[0] = 8'h0A;
            CHAR_R: bytes[0] = 8'h0D;
            CHAR_T: bytes[0] = 8'h09;
            CHAR_U: begin
              nbytes         = 3'd0;
              code_unit_next = '0;
            end
            default: begin
              nbytes  = 3'd0;
              err_now = 1'b1;
            end
          endcase
        end
        MODE_LOW_BS: if (in_byte != CHAR_BACKSLASH) err_now = 1'b1;
        MODE_LOW_U: begin
          if (in_byte != CHAR_U) err_now = 1'b1;
          else code_unit_next = '0;
        end
        MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
          if (!hexv[4]) begin
            err_now = 1'b1;
          end else begin
            code_unit_next = cu_shift;
            if (mode == MODE_HEX4) begin
              priority if (pair_pending) begin
                if (!is_low) begin
                  err_now = 1'b1;
                end else begin
                  pair_pending_next = 1'b0;
                  nbytes            = enc.nbytes;
                  bytes             = enc.bytes;
                end
              end else if (is_high) begin
                pair_pending_next = 1'b1;
                high_half_next    = cu_shift[9:0];
              end else if (is_low) begin
                err_now = 1'b1;
              end else begin
                nbytes = enc.nbytes;
                bytes  = enc.bytes;
              end
            end
          end
        end
      endcase
    end
  end

  assign error_flag_next = error_flag | err_now;

  // Saturating count: the carry out means the sum passed the top
  assign count_sum       = {1'b0, byte_count} + (COUNT_BITS+1)'(nbytes);
  assign byte_count_next = count_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}}
                                                 : count_sum[COUNT_BITS-1:0];
  assign count_ext       = 32'(byte_count_next);

  always_comb begin
    priority if (error_flag_next)         status = STATUS_MALFORMED;
    else if (mode_next != MODE_PLAIN)     status = STATUS_MALFORMED;
    else if (dfa_state_next != DFA_ACCEPT) status = STATUS_INCOMPLETE;
    else                                  status = STATUS_OK;
  end

  assign push                 = take && ((nbytes != 3'd0) || in_last);
  assign push_data.nbytes     = nbytes;
  assign push_data.bytes      = bytes;
  assign push_data.has_status = in_last;
  assign push_data.status     = status;
  assign push_data.length     = (count_ext > 32'hFFFF) ? 16'hFFFF : count_ext[15:0];

  always_ff @(posedge clk) begin
    if (rst || (take && in_last)) begin
      mode         <= MODE_PLAIN;
      dfa_state    <= DFA_ACCEPT;
      code_unit    <= '0;
      high_half    <= '0;
      pair_pending <= 1'b0;
      error_flag   <= 1'b0;
      byte_count   <= '0;
    end else if (take) begin
      mode         <= mode_next;
      dfa_state    <= dfa_state_next;
      code_unit    <= code_unit_next;
      high_half    <= high_half_next;
      pair_pending <= pair_pending_next;
      error_flag   <= error_flag_next;
      byte_count   <= byte_count_next;
    end
  end

endmodule

/* hdl/jsu_queue.sv */
module jsu_queue
  import jsu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output logic    full,
  output logic    empty
);

  bundle_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/jsu_back.sv */
module jsu_back
  import jsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  bundle_t     head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output status_t     out_status,
  output logic [15:0] out_length,
  output logic        out_last
);

  logic [2:0] idx;
  logic [2:0] total;
  logic       is_data, is_final, load;

  assign total    = head.nbytes + {2'b00, head.has_status};
  assign is_data  = (idx < head.nbytes);
  assign is_final = ((idx + 3'd1) == total);
  assign load     = !q_empty && (!out_valid || out_ready);
  assign pop      = load && is_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= is_final ? 3'd0 : idx + 3'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the payload until the next result is loaded
  always_ff @(posedge clk) begin
    if (load) begin
      out_kind   <= is_data ? KIND_DATA : KIND_STATUS;
      out_byte   <= is_data ? head.bytes[idx[1:0]] : 8'd0;
      out_status <= is_data ? STATUS_OK : head.status;
      out_length <= is_data ? 16'd0 : head.length;
      out_last   <= is_final;
    end
  end

endmodule

/* hdl/json_string_unescaper_core.sv */
// JSON string body unescaper. Feed the text between the quotes one byte per
// transaction; tuser set means tdata carries a byte, and tlast closes the string
// (tuser clear with tlast set closes an empty string). Raw bytes are checked as
// UTF-8 and passed through; escapes, including \uXXXX and surrogate pairs, come
// out as UTF-8. The closing transaction also yields a status result (tuser set)
// giving ok, malformed or incomplete UTF-8 and the decoded length, saturated at
// 65535; on error data output stops until the string is closed. tlast on the
// output marks the last result of each input transaction. Input is taken one
// byte per cycle while the queue is not full; the output drains one result per
// cycle while tready is high, so an escape that expands to 2 to 4 bytes yields
// that many results, held in a four-entry queue between decoder and serialiser.
module json_string_unescaper_core
  import jsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [9:8] status, [25:10] out_length
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast
);

  logic        push, pop, q_full, q_empty;
  bundle_t     push_data, head;
  logic [7:0]  out_byte;
  status_t     out_status;
  logic [15:0] out_length;

  jsu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_byte       (s_axis_tdata),
    .in_byte_valid (s_axis_tuser),
    .in_last       (s_axis_tlast),
    .in_ready      (s_axis_tready),
    .q_full        (q_full),
    .push          (push),
    .push_data     (push_data)
  );

  jsu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (m_axis_tuser),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_length (out_length),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_length, out_status, out_byte};

  a_status_closes_run: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_STATUS) |-> m_axis_tlast)
    else $error("status result without run end");

  a_data_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_DATA) |->
      (m_axis_tdata[25:8] == 18'd0))
    else $error("data result carries status or length");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    (q_empty && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result appeared with nothing queued");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> (!push || pop == 1'b0) && !s_axis_tready)
    else $error("queue written while full");

endmodule
